// ===== rtl/paced_ab_flash_autosave_controller_macros.svh =====
// Assertion macros shared by the checker of the paced A/B flash autosave controller.
// Relies on i_clk and i_rst_n being visible in the scope that uses them.
`ifndef PACED_AB_FLASH_AUTOSAVE_CONTROLLER_MACROS_SVH
`define PACED_AB_FLASH_AUTOSAVE_CONTROLLER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define PAFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define PAFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pafc_pkg.sv =====
// Shared types, codes and constants for the paced A/B flash autosave controller.
// No dependencies; used by pafc_step, the top level and the checker.
`default_nettype none

package pafc_pkg;

    // Default geometry
    localparam int DEF_SECTORS_PER_SLOT = 9;
    localparam int DEF_CHUNK_BYTES      = 512;
    localparam int DEF_MAX_SAVE_BYTES   = 32768;

    // Fixed field widths
    localparam int BLANK_BITS = 9;
    localparam int SECT_W     = 4;
    localparam int SAVE_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLICED_ERASE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAVE_BYTES     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_SEQ      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_SLOT     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTOSAVE_IVL   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ERASE_SPACING  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_TICKS    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_WAIT_MAX = 4'd7;

    // Register values after reset
    localparam logic [SAVE_W-1:0] RST_SAVE_BYTES     = 16'd32768;
    localparam logic [15:0]       RST_AUTOSAVE_IVL   = 16'd3000;
    localparam logic [15:0]       RST_ERASE_SPACING  = 16'd200;
    localparam logic [3:0]        RST_QUIET_TICKS    = 4'd4;
    localparam logic [15:0]       RST_QUIET_WAIT_MAX = 16'd2000;

    typedef enum logic [1:0] {
        PH_IDLE        = 2'd0,
        PH_ERASING     = 2'd1,
        PH_READY       = 2'd2,
        PH_PROGRAMMING = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        CMD_NONE        = 3'd0,
        CMD_SLICE_BEGIN = 3'd1,
        CMD_SLICE_STEP  = 3'd2,
        CMD_BLOCK_ERASE = 3'd3,
        CMD_PROG_CHUNK  = 3'd4,
        CMD_PROG_HEADER = 3'd5
    } t_cmd;

    typedef struct packed {
        logic              sliced_erase;
        logic [SAVE_W-1:0] save_bytes;
        logic [15:0]       save_period_ms;
        logic [15:0]       erase_pace_ms;
        logic [3:0]        quiet_ticks_needed;
        logic [15:0]       quiet_limit_ms;
    } t_cfg;

    typedef struct packed {
        t_phase            phase;
        logic              dirty;
        logic [3:0]        quiet_count;
        logic [31:0]       last_save_time;
        logic [SECT_W-1:0] erase_index;
        logic [31:0]       last_erase_time;
        logic              erase_suspended;
        logic              quiet_wait_on;
        logic [31:0]       due_wait_start;
        logic [SAVE_W-1:0] program_offset;
        logic [31:0]       staged_seq;
        logic [31:0]       live_seq;
        logic              target_slot;
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/pafc_step.sv =====
// One poll tick of the autosave controller: next state and flash command.
// Purely combinational; depends on pafc_pkg.
`default_nettype none

module pafc_step #(
    parameter int SECTORS_PER_SLOT = pafc_pkg::DEF_SECTORS_PER_SLOT,
    parameter int CHUNK_BYTES      = pafc_pkg::DEF_CHUNK_BYTES,
    parameter int MAX_SAVE_BYTES   = pafc_pkg::DEF_MAX_SAVE_BYTES
) (
    input  var pafc_pkg::t_state                       i_state,
    input  var pafc_pkg::t_cfg                         i_cfg,
    input  wire                                        i_wrote,
    input  wire [31:0]                                 i_now_ms,
    input  wire [pafc_pkg::BLANK_BITS-1:0]             i_blank_mask,
    input  wire                                        i_slice_done,
    output pafc_pkg::t_state                           o_state,
    output logic [2:0]                                 o_command,
    output logic                                       o_slot,
    output logic [pafc_pkg::SECT_W-1:0]                o_sector,
    output logic [$clog2(MAX_SAVE_BYTES)-1:0]          o_data_offset,
    output logic [$clog2(CHUNK_BYTES+1)-1:0]           o_chunk_bytes,
    output logic [31:0]                                o_commit_seq,
    output logic                                       o_saving,
    output logic [1:0]                                 o_phase
);
    import pafc_pkg::*;

    localparam int OFF_W = $clog2(MAX_SAVE_BYTES);
    localparam int CHK_W = $clog2(CHUNK_BYTES + 1);
    localparam logic [SAVE_W:0]   MAX_SIZE  = (SAVE_W+1)'(MAX_SAVE_BYTES);
    localparam logic [SAVE_W:0]   CHUNK_LEN = (SAVE_W+1)'(CHUNK_BYTES);
    localparam logic [SECT_W-1:0] SECT_END  = SECT_W'(SECTORS_PER_SLOT);

    t_state            n_s;
    t_cmd              cmd;
    logic              go;
    logic [SECT_W-1:0] srch_start;
    logic [SECT_W-1:0] srch_idx;
    logic              srch_found;
    logic [15:0]       mask_ext;
    logic              erase_gap_ok;
    logic              save_gap_ok;
    logic              wait_gap_ok;
    logic [31:0]       seq_inc;
    logic [31:0]       seq_next;
    logic [SAVE_W:0]   size;
    logic [SAVE_W:0]   remain;
    logic [SECT_W-1:0] ers_sector;
    logic [SAVE_W-1:0] prog_off;
    logic [SAVE_W:0]   prog_len;
    logic [31:0]       hdr_seq;

    // Sectors past the mask count as not blank.
    assign mask_ext   = 16'(i_blank_mask);
    assign srch_start = (i_state.phase == PH_IDLE) ? '0 : i_state.erase_index;

    // First sector at or after the start index that still needs erasing.
    always_comb begin
        srch_found = 1'b0;
        srch_idx   = SECT_END;
        for (int i = 0; i < SECTORS_PER_SLOT; i++) begin
            if (!srch_found && SECT_W'(i) >= srch_start && !mask_ext[i]) begin
                srch_found = 1'b1;
                srch_idx   = SECT_W'(i);
            end
        end
    end

    // Entering the erase phase backdates the last erase, so the gap is met at once.
    assign erase_gap_ok = (i_state.phase == PH_IDLE)
        || ((i_now_ms - i_state.last_erase_time) >= 32'(i_cfg.erase_pace_ms));
    assign save_gap_ok  = (i_now_ms - i_state.last_save_time)
        >= 32'(i_cfg.save_period_ms);
    assign wait_gap_ok  = (i_now_ms - i_state.due_wait_start)
        >= 32'(i_cfg.quiet_limit_ms);

    assign seq_inc  = i_state.live_seq + 32'd1;
    assign seq_next = (seq_inc == '0) ? 32'd1 : seq_inc;

    assign size = ({1'b0, i_cfg.save_bytes} > MAX_SIZE) ? MAX_SIZE : {1'b0, i_cfg.save_bytes};

    // Phase progression: one tick may run through several phases.
    always_comb begin
        n_s        = i_state;
        cmd        = CMD_NONE;
        go         = 1'b1;
        ers_sector = '0;
        prog_off   = '0;
        prog_len   = '0;
        hdr_seq    = '0;
        remain     = '0;

        if (i_wrote) begin
            n_s.dirty       = 1'b1;
            n_s.quiet_count = '0;
        end else if (i_state.quiet_count < i_cfg.quiet_ticks_needed) begin
            n_s.quiet_count = i_state.quiet_count + 4'd1;
        end

        if (i_state.phase == PH_IDLE) begin
            if (!n_s.dirty) begin
                go = 1'b0;
            end else begin
                n_s.erase_index     = '0;
                n_s.last_erase_time = i_now_ms - 32'(i_cfg.erase_pace_ms);
                n_s.phase           = PH_ERASING;
            end
        end

        if (go && n_s.phase == PH_ERASING) begin
            go = 1'b0;
            if (n_s.erase_suspended) begin
                cmd        = CMD_SLICE_STEP;
                ers_sector = n_s.erase_index;
                if (i_slice_done) begin
                    n_s.erase_suspended = 1'b0;
                    n_s.erase_index     = n_s.erase_index + 4'd1;
                end
            end else begin
                n_s.erase_index = srch_idx;
                if (srch_found) begin
                    if (i_cfg.sliced_erase) begin
                        cmd        = CMD_SLICE_BEGIN;
                        ers_sector = srch_idx;
                        if (i_slice_done) begin
                            n_s.erase_index = srch_idx + 4'd1;
                        end else begin
                            n_s.erase_suspended = 1'b1;
                        end
                    end else if (erase_gap_ok) begin
                        cmd                 = CMD_BLOCK_ERASE;
                        ers_sector          = srch_idx;
                        n_s.erase_index     = srch_idx + 4'd1;
                        n_s.last_erase_time = i_now_ms;
                    end
                end else begin
                    go                = 1'b1;
                    n_s.phase         = PH_READY;
                    n_s.quiet_wait_on = 1'b0;
                end
            end
        end

        if (go && n_s.phase == PH_READY) begin
            if (!n_s.dirty || !save_gap_ok) begin
                go = 1'b0;
            end else if (n_s.quiet_count < i_cfg.quiet_ticks_needed) begin
                if (!n_s.quiet_wait_on) begin
                    n_s.quiet_wait_on  = 1'b1;
                    n_s.due_wait_start = i_now_ms;
                    if (i_cfg.quiet_limit_ms != '0) begin
                        go = 1'b0;
                    end
                end else if (!wait_gap_ok) begin
                    go = 1'b0;
                end
            end
            if (go) begin
                n_s.staged_seq     = seq_next;
                n_s.dirty          = 1'b0;
                n_s.program_offset = '0;
                n_s.phase          = PH_PROGRAMMING;
            end
        end

        if (go && n_s.phase == PH_PROGRAMMING) begin
            remain = size - {1'b0, n_s.program_offset};
            if ({1'b0, n_s.program_offset} < size) begin
                cmd                = CMD_PROG_CHUNK;
                prog_off           = n_s.program_offset;
                prog_len           = (remain < CHUNK_LEN) ? remain : CHUNK_LEN;
                n_s.program_offset = n_s.program_offset + prog_len[SAVE_W-1:0];
            end else begin
                cmd                = CMD_PROG_HEADER;
                hdr_seq            = n_s.staged_seq;
                n_s.live_seq       = n_s.staged_seq;
                n_s.target_slot    = ~n_s.target_slot;
                n_s.last_save_time = i_now_ms;
                n_s.phase          = PH_IDLE;
            end
        end
    end

    assign o_state = n_s;

    // Result fields: anything the command does not use reads as zero.
    always_comb begin
        o_command     = cmd;
        o_slot        = 1'b0;
        o_sector      = '0;
        o_data_offset = '0;
        o_chunk_bytes = '0;
        o_commit_seq  = '0;
        unique case (cmd) inside
            CMD_SLICE_BEGIN, CMD_SLICE_STEP, CMD_BLOCK_ERASE: begin
                o_slot   = i_state.target_slot;
                o_sector = ers_sector;
            end
            CMD_PROG_CHUNK: begin
                o_slot        = i_state.target_slot;
                o_data_offset = prog_off[OFF_W-1:0];
                o_chunk_bytes = prog_len[CHK_W-1:0];
            end
            CMD_PROG_HEADER: begin
                o_slot       = i_state.target_slot;
                o_commit_seq = hdr_seq;
            end
            default: begin
                o_slot = 1'b0;
            end
        endcase
        o_phase  = n_s.phase;
        o_saving = (n_s.phase == PH_PROGRAMMING);
    end

endmodule

`default_nettype wire

// ===== rtl/paced_ab_flash_autosave_controller.sv =====
// A tick word accepted into the input register passes through the step logic into the
// output register, from which its command word is taken. The state loop is one
// pafc_step pass per tick; one tick word is taken per cycle unless i_stall blocks it.
// The input register refills while the output register still holds an untaken word.
// Reset (synchronous, active low) restores state, config and valid flags, not data.
// Depends on pafc_pkg and pafc_step.
`default_nettype none

module paced_ab_flash_autosave_controller #(
    parameter int SECTORS_PER_SLOT = pafc_pkg::DEF_SECTORS_PER_SLOT,
    parameter int CHUNK_BYTES      = pafc_pkg::DEF_CHUNK_BYTES,
    parameter int MAX_SAVE_BYTES   = pafc_pkg::DEF_MAX_SAVE_BYTES
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // Tick words in
    input  wire                                    i_valid,
    output logic                                   o_stall,
    input  wire                                    i_wrote,
    input  wire [31:0]                             i_now_ms,
    input  wire [pafc_pkg::BLANK_BITS-1:0]         i_blank_mask,
    input  wire                                    i_slice_done,
    // Command words out
    output logic                                   o_valid,
    input  wire                                    i_stall,
    output logic [2:0]                             o_command,
    output logic                                   o_slot,
    output logic [pafc_pkg::SECT_W-1:0]            o_sector,
    output logic [$clog2(MAX_SAVE_BYTES)-1:0]      o_data_offset,
    output logic [$clog2(CHUNK_BYTES+1)-1:0]       o_chunk_bytes,
    output logic [31:0]                            o_commit_seq,
    output logic                                   o_saving,
    output logic [1:0]                             o_phase,
    // Configuration writes
    input  wire                                    i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire [pafc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire [pafc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import pafc_pkg::*;

    localparam int OFF_W = $clog2(MAX_SAVE_BYTES);
    localparam int CHK_W = $clog2(CHUNK_BYTES + 1);

    // The block is a two-stage pipe. The input register holds the accepted tick;
    // the step logic turns it and the controller state into a command, which
    // lands in the output register in the same edge that updates the state.
    // The state therefore advances exactly once per tick, in tick order.

    logic                  r_in_valid;
    logic                  r_wrote;
    logic [31:0]           r_now_ms;
    logic [BLANK_BITS-1:0] r_blank_mask;
    logic                  r_slice_done;

    logic                  r_out_valid;
    logic [2:0]            r_command;
    logic                  r_slot;
    logic [SECT_W-1:0]     r_sector;
    logic [OFF_W-1:0]      r_data_offset;
    logic [CHK_W-1:0]      r_chunk_bytes;
    logic [31:0]           r_commit_seq;
    logic                  r_saving;
    logic [1:0]            r_phase;

    t_state                r_state;
    t_state                n_state;
    t_cfg                  r_cfg;

    t_state                step_state;
    logic [2:0]            step_command;
    logic                  step_slot;
    logic [SECT_W-1:0]     step_sector;
    logic [OFF_W-1:0]      step_data_offset;
    logic [CHK_W-1:0]      step_chunk_bytes;
    logic [31:0]           step_commit_seq;
    logic                  step_saving;
    logic [1:0]            step_phase;

    logic                  advance;
    logic                  in_take;
    logic                  cfg_wr;

    // A tick moves on when the output register is empty or being emptied.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    // Writes are only meaningful while idle; holding them off while a tick
    // sits in the input register keeps the start registers clear of the step.
    assign o_cfg_ready = !r_in_valid;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    pafc_step #(
        .SECTORS_PER_SLOT (SECTORS_PER_SLOT),
        .CHUNK_BYTES      (CHUNK_BYTES),
        .MAX_SAVE_BYTES   (MAX_SAVE_BYTES)
    ) u_step (
        .i_state       (r_state),
        .i_cfg         (r_cfg),
        .i_wrote       (r_wrote),
        .i_now_ms      (r_now_ms),
        .i_blank_mask  (r_blank_mask),
        .i_slice_done  (r_slice_done),
        .o_state       (step_state),
        .o_command     (step_command),
        .o_slot        (step_slot),
        .o_sector      (step_sector),
        .o_data_offset (step_data_offset),
        .o_chunk_bytes (step_chunk_bytes),
        .o_commit_seq  (step_commit_seq),
        .o_saving      (step_saving),
        .o_phase       (step_phase)
    );

    // Loading a start register also reloads the live sequence number or slot.
    always_comb begin
        n_state = advance ? step_state : r_state;
        if (cfg_wr && i_cfg_index == REG_START_SEQ) begin
            n_state.live_seq = i_cfg_data;
        end
        if (cfg_wr && i_cfg_index == REG_START_SLOT) begin
            n_state.target_slot = i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, default: '0};
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sliced_erase       <= 1'b0;
            r_cfg.save_bytes         <= RST_SAVE_BYTES;
            r_cfg.save_period_ms     <= RST_AUTOSAVE_IVL;
            r_cfg.erase_pace_ms      <= RST_ERASE_SPACING;
            r_cfg.quiet_ticks_needed <= RST_QUIET_TICKS;
            r_cfg.quiet_limit_ms     <= RST_QUIET_WAIT_MAX;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_SLICED_ERASE:   r_cfg.sliced_erase       <= i_cfg_data[0];
                REG_SAVE_BYTES:     r_cfg.save_bytes         <= i_cfg_data[SAVE_W-1:0];
                REG_AUTOSAVE_IVL:   r_cfg.save_period_ms     <= i_cfg_data[15:0];
                REG_ERASE_SPACING:  r_cfg.erase_pace_ms      <= i_cfg_data[15:0];
                REG_QUIET_TICKS:    r_cfg.quiet_ticks_needed <= i_cfg_data[3:0];
                REG_QUIET_WAIT_MAX: r_cfg.quiet_limit_ms     <= i_cfg_data[15:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_wrote      <= i_wrote;
            r_now_ms     <= i_now_ms;
            r_blank_mask <= i_blank_mask;
            r_slice_done <= i_slice_done;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_command     <= step_command;
            r_slot        <= step_slot;
            r_sector      <= step_sector;
            r_data_offset <= step_data_offset;
            r_chunk_bytes <= step_chunk_bytes;
            r_commit_seq  <= step_commit_seq;
            r_saving      <= step_saving;
            r_phase       <= step_phase;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_command     = r_command;
    assign o_slot        = r_slot;
    assign o_sector      = r_sector;
    assign o_data_offset = r_data_offset;
    assign o_chunk_bytes = r_chunk_bytes;
    assign o_commit_seq  = r_commit_seq;
    assign o_saving      = r_saving;
    assign o_phase       = r_phase;

endmodule

`default_nettype wire

// ===== rtl/pafc_checker.sv =====
// Port-level checker for the paced A/B flash autosave controller, bound to the top level.
// Depends on pafc_pkg and the assertion macro header.
`default_nettype none
`include "paced_ab_flash_autosave_controller_macros.svh"

module pafc_checker #(
    parameter int CHUNK_BYTES    = pafc_pkg::DEF_CHUNK_BYTES,
    parameter int MAX_SAVE_BYTES = pafc_pkg::DEF_MAX_SAVE_BYTES
) (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               o_valid,
    input wire                               i_stall,
    input wire [2:0]                         o_command,
    input wire                               o_slot,
    input wire [pafc_pkg::SECT_W-1:0]        o_sector,
    input wire [$clog2(MAX_SAVE_BYTES)-1:0]  o_data_offset,
    input wire [$clog2(CHUNK_BYTES+1)-1:0]   o_chunk_bytes,
    input wire [31:0]                        o_commit_seq,
    input wire                               o_saving,
    input wire [1:0]                         o_phase
);
    import pafc_pkg::*;

    // A word held back by the consumer stays put.
    `PAFC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_command) && $stable(o_commit_seq), "command word changed while stalled")

    // With no command, every command field reads as zero.
    `PAFC_ASSERT_NOW(a_none_zero, o_valid && o_command == CMD_NONE, !o_slot && o_sector == '0 && o_data_offset == '0 && o_chunk_bytes == '0 && o_commit_seq == '0, "fields set without a command")

    `PAFC_ASSERT_NOW(a_saving_phase, o_valid, o_saving == (o_phase == PH_PROGRAMMING), "saving flag disagrees with phase")

    // The commit header ends a save and never carries sequence zero.
    `PAFC_ASSERT_NOW(a_header, o_valid && o_command == CMD_PROG_HEADER, o_phase == PH_IDLE && o_commit_seq != '0, "bad commit header")

    `PAFC_ASSERT_NOW(a_chunk, o_valid && o_command == CMD_PROG_CHUNK, o_phase == PH_PROGRAMMING && o_chunk_bytes != '0, "empty chunk or chunk outside programming")

endmodule

bind paced_ab_flash_autosave_controller pafc_checker #(
    .CHUNK_BYTES    (CHUNK_BYTES),
    .MAX_SAVE_BYTES (MAX_SAVE_BYTES)
) u_pafc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_command     (o_command),
    .o_slot        (o_slot),
    .o_sector      (o_sector),
    .o_data_offset (o_data_offset),
    .o_chunk_bytes (o_chunk_bytes),
    .o_commit_seq  (o_commit_seq),
    .o_saving      (o_saving),
    .o_phase       (o_phase)
);

`default_nettype wire
